FILE: rtl/usp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package usp_pkg;

	// default capacities, handed to the top level parameters
	localparam int HOST_CAP_DEF = 256;
	localparam int PATH_CAP_DEF = 1024;

	// port limits and defaults
	localparam logic [16:0] PORT_MAX   = 17'd65535;
	localparam logic [16:0] PORT_SAT   = 17'd65536;
	localparam logic [15:0] PORT_TLS   = 16'd443;
	localparam logic [15:0] PORT_PLAIN = 16'd80;

	// highest byte position before the url is too long
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// characters the parser looks for
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_SEP,
		PH_HOST,
		PH_PORT,
		PH_PATH
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SCHEME  = 3'd1,
		ERR_HOST    = 3'd2,
		ERR_PORT    = 3'd3,
		ERR_PATH    = 3'd4,
		ERR_URL_LEN = 3'd5
	} err_t;

	// port sub-phase: whitespace skipping, sign seen, digits seen
	typedef enum logic [1:0] {
		PS_WS,
		PS_SIGN,
		PS_DIGIT
	} psub_t;

	typedef enum logic [1:0] {
		SC_HTTP,
		SC_HTTPS,
		SC_WS,
		SC_WSS
	} scheme_t;

	// one result transaction
	typedef struct packed {
		logic        valid_res;
		err_t        error;
		logic [1:0]  scheme_code;
		logic        is_tls;
		logic [15:0] port;
		logic        port_given;
		logic [3:0]  host_offset;
		logic [7:0]  host_length;
		logic [15:0] path_offset;
		logic [9:0]  path_length;
	} res_t;

	// pipeline control from the parse core
	typedef struct packed {
		logic advance;
		logic load;
	} ctl_t;

	// scheme name length
	function automatic logic [2:0] scheme_name_len(input scheme_t k);
		logic [2:0] len;
		case (k)
			SC_HTTP:  len = 3'd4;
			SC_HTTPS: len = 3'd5;
			SC_WS:    len = 3'd2;
			SC_WSS:   len = 3'd3;
			default:  len = 3'd0;
		endcase
		return len;
	endfunction

	// scheme name character at index i
	function automatic logic [7:0] scheme_char(input scheme_t k, input logic [2:0] i);
		logic [7:0] ch;
		ch = CH_NUL;
		case (k)
			SC_HTTP, SC_HTTPS: begin
				case (i)
					3'd0:    ch = 8'h68;
					3'd1:    ch = 8'h74;
					3'd2:    ch = 8'h74;
					3'd3:    ch = 8'h70;
					3'd4:    ch = (k == SC_HTTPS) ? 8'h73 : CH_NUL;
					default: ch = CH_NUL;
				endcase
			end
			SC_WS, SC_WSS: begin
				case (i)
					3'd0:    ch = 8'h77;
					3'd1:    ch = 8'h73;
					3'd2:    ch = (k == SC_WSS) ? 8'h73 : CH_NUL;
					default: ch = CH_NUL;
				endcase
			end
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/usp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module usp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_req,
	input  wire logic       last,
	input  wire usp_pkg::ctl_t ctl,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            last_s1
);

	logic take;

	// accept while the stage is empty or drains this cycle
	assign in_stall = valid_s1 && !ctl.advance;
	assign take     = in_valid && !in_stall;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_req;
			last_s1 <= last;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/usp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module usp_core #(
	parameter int HOST_CAP = usp_pkg::HOST_CAP_DEF,
	parameter int PATH_CAP = usp_pkg::PATH_CAP_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire logic [7:0] byte_s1,
	input  wire logic       last_s1,
	input  wire logic       out_free,
	output usp_pkg::ctl_t   ctl,
	output usp_pkg::res_t   res
);

	localparam int HOST_CW = $clog2(HOST_CAP + 1);
	localparam int PATH_CW = $clog2(PATH_CAP + 1);
	localparam logic [HOST_CW-1:0] HOST_LIM = HOST_CW'(HOST_CAP);
	localparam logic [PATH_CW-1:0] PATH_LIM = PATH_CW'(PATH_CAP);

	// parse state
	usp_pkg::phase_t     phase_q;
	logic [3:0]          match_q;
	logic                sep_q;
	logic [15:0]         pos_q;
	logic [HOST_CW-1:0]  host_q;
	logic [16:0]         pval_q;
	usp_pkg::psub_t      psub_q;
	logic [PATH_CW-1:0]  pathc_q;
	logic [15:0]         ppos_q;
	usp_pkg::err_t       err_q;

	// state after the byte is consumed
	usp_pkg::phase_t     phase_c;
	logic [3:0]          match_c;
	logic                sep_c;
	logic [15:0]         pos_c;
	logic [HOST_CW-1:0]  host_c;
	logic [16:0]         pval_c;
	usp_pkg::psub_t      psub_c;
	logic [PATH_CW-1:0]  pathc_c;
	logic [15:0]         ppos_c;
	usp_pkg::err_t       err_c;
	usp_pkg::err_t       err_f;

	logic ends;
	logic port_bad;
	logic [20:0] pmul;

	assign ends = (byte_s1 == usp_pkg::CH_NUL) || last_s1;
	assign ctl.advance = valid_s1 && (!ends || out_free);
	assign ctl.load    = ctl.advance && ends;

	// port value after one more digit
	assign pmul = 21'({pval_q, 3'b000}) + 21'({pval_q, 1'b0}) + 21'(byte_s1 - usp_pkg::CH_ZERO);

	// port check at the end of the port
	assign port_bad = (psub_q != usp_pkg::PS_DIGIT) || (pval_q == 17'd0)
		|| (pval_q > usp_pkg::PORT_MAX);

	// consume one byte
	always_comb begin
		logic [3:0] m;
		phase_c = phase_q;
		match_c = match_q;
		sep_c   = sep_q;
		pos_c   = pos_q;
		host_c  = host_q;
		pval_c  = pval_q;
		psub_c  = psub_q;
		pathc_c = pathc_q;
		ppos_c  = ppos_q;
		err_c   = err_q;
		m       = 4'b0000;
		if (byte_s1 != usp_pkg::CH_NUL && err_q == usp_pkg::ERR_NONE) begin
			if (pos_q == usp_pkg::POS_MAX) begin
				err_c = usp_pkg::ERR_URL_LEN;
			end else begin
				pos_c = pos_q + 16'd1;
				case (phase_q)
					usp_pkg::PH_SCHEME: begin
						if (byte_s1 == usp_pkg::CH_COLON) begin
							for (int k = 0; k < 4; k++) begin
								if (match_q[k]
										&& 16'(usp_pkg::scheme_name_len(usp_pkg::scheme_t'(k)))
										== pos_q) begin
									m = 4'b0001 << k;
								end
							end
							if (m == 4'b0000) begin
								err_c = usp_pkg::ERR_SCHEME;
							end else begin
								match_c = m;
								phase_c = usp_pkg::PH_SEP;
								sep_c   = 1'b0;
							end
						end else begin
							for (int k = 0; k < 4; k++) begin
								if (match_q[k]
										&& pos_q
										< 16'(usp_pkg::scheme_name_len(usp_pkg::scheme_t'(k)))
										&& usp_pkg::scheme_char(usp_pkg::scheme_t'(k), pos_q[2:0])
										== byte_s1) begin
									m[k] = 1'b1;
								end
							end
							if (m == 4'b0000) begin
								err_c = usp_pkg::ERR_SCHEME;
							end else begin
								match_c = m;
							end
						end
					end
					usp_pkg::PH_SEP: begin
						if (byte_s1 != usp_pkg::CH_SLASH) begin
							err_c = usp_pkg::ERR_SCHEME;
						end else if (sep_q) begin
							phase_c = usp_pkg::PH_HOST;
							sep_c   = 1'b0;
						end else begin
							sep_c = 1'b1;
						end
					end
					usp_pkg::PH_HOST: begin
						if (byte_s1 == usp_pkg::CH_COLON) begin
							if (host_q == '0) begin
								err_c = usp_pkg::ERR_HOST;
							end else begin
								phase_c = usp_pkg::PH_PORT;
								psub_c  = usp_pkg::PS_WS;
								pval_c  = 17'd0;
							end
						end else if (byte_s1 == usp_pkg::CH_SLASH) begin
							if (host_q == '0) begin
								err_c = usp_pkg::ERR_HOST;
							end else begin
								phase_c = usp_pkg::PH_PATH;
								ppos_c  = pos_q;
								pathc_c = PATH_CW'(1);
							end
						end else begin
							host_c = host_q + HOST_CW'(1);
							if (host_c >= HOST_LIM) begin
								err_c = usp_pkg::ERR_HOST;
							end
						end
					end
					usp_pkg::PH_PORT: begin
						if (byte_s1 == usp_pkg::CH_SLASH) begin
							if (port_bad) begin
								err_c = usp_pkg::ERR_PORT;
							end else begin
								phase_c = usp_pkg::PH_PATH;
								ppos_c  = pos_q;
								pathc_c = PATH_CW'(1);
							end
						end else if (byte_s1 inside {[usp_pkg::CH_ZERO:usp_pkg::CH_NINE]}) begin
							pval_c = (pmul > 21'(usp_pkg::PORT_SAT)) ? usp_pkg::PORT_SAT
								: pmul[16:0];
							psub_c = usp_pkg::PS_DIGIT;
						end else if (psub_q == usp_pkg::PS_WS && (byte_s1 == usp_pkg::CH_SPACE
								|| byte_s1 inside {[usp_pkg::CH_TAB:usp_pkg::CH_CR]})) begin
							psub_c = usp_pkg::PS_WS;
						end else if (psub_q == usp_pkg::PS_WS && byte_s1 == usp_pkg::CH_PLUS) begin
							psub_c = usp_pkg::PS_SIGN;
						end else begin
							err_c = usp_pkg::ERR_PORT;
						end
					end
					default: begin
						pathc_c = pathc_q + PATH_CW'(1);
						if (pathc_c >= PATH_LIM) begin
							err_c = usp_pkg::ERR_PATH;
						end
					end
				endcase
			end
		end
	end

	// final error checks at the end of the url
	always_comb begin
		err_f = err_c;
		if (err_c == usp_pkg::ERR_NONE) begin
			case (phase_c)
				usp_pkg::PH_SCHEME, usp_pkg::PH_SEP: err_f = usp_pkg::ERR_SCHEME;
				usp_pkg::PH_HOST: begin
					if (host_c == '0) begin
						err_f = usp_pkg::ERR_HOST;
					end
				end
				usp_pkg::PH_PORT: begin
					if ((psub_c != usp_pkg::PS_DIGIT) || (pval_c == 17'd0)
							|| (pval_c > usp_pkg::PORT_MAX)) begin
						err_f = usp_pkg::ERR_PORT;
					end
				end
				default: err_f = usp_pkg::ERR_NONE;
			endcase
		end
	end

	// result fields
	always_comb begin
		usp_pkg::scheme_t k;
		logic tls;
		k = usp_pkg::SC_HTTP;
		for (int i = 3; i >= 0; i--) begin
			if (match_c[i]) begin
				k = usp_pkg::scheme_t'(i);
			end
		end
		tls = (k == usp_pkg::SC_HTTPS) || (k == usp_pkg::SC_WSS);
		res = '0;
		res.error = err_f;
		if (err_f == usp_pkg::ERR_NONE) begin
			res.valid_res   = 1'b1;
			res.scheme_code = k;
			res.is_tls      = tls;
			if (psub_c == usp_pkg::PS_DIGIT && phase_c != usp_pkg::PH_HOST
					&& (phase_c == usp_pkg::PH_PORT || pval_c != 17'd0)) begin
				res.port       = pval_c[15:0];
				res.port_given = 1'b1;
			end else begin
				res.port = tls ? usp_pkg::PORT_TLS : usp_pkg::PORT_PLAIN;
			end
			res.host_offset = 4'(usp_pkg::scheme_name_len(k)) + 4'd3;
			res.host_length = 8'(host_c);
			if (phase_c == usp_pkg::PH_PATH) begin
				res.path_offset = ppos_c;
				res.path_length = 10'(pathc_c);
			end
		end
	end

	// control state, back to its start values after each url
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= usp_pkg::PH_SCHEME;
			match_q <= 4'b1111;
			sep_q   <= 1'b0;
			pos_q   <= 16'd0;
			host_q  <= '0;
			pval_q  <= 17'd0;
			psub_q  <= usp_pkg::PS_WS;
			pathc_q <= '0;
			ppos_q  <= 16'd0;
			err_q   <= usp_pkg::ERR_NONE;
		end else if (ctl.advance) begin
			if (ends) begin
				phase_q <= usp_pkg::PH_SCHEME;
				match_q <= 4'b1111;
				sep_q   <= 1'b0;
				pos_q   <= 16'd0;
				host_q  <= '0;
				pval_q  <= 17'd0;
				psub_q  <= usp_pkg::PS_WS;
				pathc_q <= '0;
				ppos_q  <= 16'd0;
				err_q   <= usp_pkg::ERR_NONE;
			end else begin
				phase_q <= phase_c;
				match_q <= match_c;
				sep_q   <= sep_c;
				pos_q   <= pos_c;
				host_q  <= host_c;
				pval_q  <= pval_c;
				psub_q  <= psub_c;
				pathc_q <= pathc_c;
				ppos_q  <= ppos_c;
				err_q   <= err_c;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/usp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module usp_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire usp_pkg::ctl_t ctl,
	input  wire usp_pkg::res_t res,
	input  wire logic          out_stall,
	output logic               out_valid,
	output logic               out_free,
	output usp_pkg::res_t      res_q
);

	// the register can take a result when empty or being drained
	assign out_free = !out_valid || !out_stall;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/url_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// url_stream_parser: streaming parser for scheme://host[:port][/path]
//
// input channel: one url byte per transaction (byte_req, last) with in_valid
// and in_stall. a zero byte or last set ends the url; a zero byte is not
// part of it. output channel: one result transaction per url on out_valid
// and out_stall, carrying scheme, port, host and path offsets and lengths,
// or an error code with all other fields zero.
//
// timing: each byte is parsed while it sits in the input register, where
// the parse state is updated; a url's final byte waits there until the
// output register is free, and its result is then loaded into the output
// register, raising out_valid. a byte that does not end a url can be
// accepted every cycle, also while a result waits; throughput is one byte
// per cycle while no final byte waits in the input register.
//
// reset: arst_n clears both registers' valid flags and returns the parse
// state to the start of a url. when the receiver stalls, the result holds;
// bytes that do not end a url keep flowing, and a byte that ends a url
// waits in the input register until the output register is free.
module url_stream_parser #(
	parameter int HOST_CAP = usp_pkg::HOST_CAP_DEF,
	parameter int PATH_CAP = usp_pkg::PATH_CAP_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_req,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            valid_res,
	output logic [2:0]      error,
	output logic [1:0]      scheme_code,
	output logic            is_tls,
	output logic [15:0]     port,
	output logic            port_given,
	output logic [3:0]      host_offset,
	output logic [7:0]      host_length,
	output logic [15:0]     path_offset,
	output logic [9:0]      path_length
);

	usp_pkg::ctl_t ctl;
	usp_pkg::res_t res;
	usp_pkg::res_t res_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic          out_free;

	// input register
	usp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.byte_req (byte_req),
		.last     (last),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	// parse state and result logic
	usp_core #(
		.HOST_CAP (HOST_CAP),
		.PATH_CAP (PATH_CAP)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.out_free (out_free),
		.ctl      (ctl),
		.res      (res)
	);

	// result register
	usp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_free  (out_free),
		.res_q     (res_q)
	);

	// result fields onto the ports
	assign valid_res   = res_q.valid_res;
	assign error       = res_q.error;
	assign scheme_code = res_q.scheme_code;
	assign is_tls      = res_q.is_tls;
	assign port        = res_q.port;
	assign port_given  = res_q.port_given;
	assign host_offset = res_q.host_offset;
	assign host_length = res_q.host_length;
	assign path_offset = res_q.path_offset;
	assign path_length = res_q.path_length;

endmodule

`default_nettype wire

FILE: rtl/usp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module usp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  byte_req,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        valid_res,
	input wire logic [2:0]  error,
	input wire logic [1:0]  scheme_code,
	input wire logic        is_tls,
	input wire logic [15:0] port,
	input wire logic        port_given,
	input wire logic [3:0]  host_offset,
	input wire logic [7:0]  host_length,
	input wire logic [15:0] path_offset,
	input wire logic [9:0]  path_length
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({valid_res, error, scheme_code,
			is_tls, port, port_given, host_offset, host_length, path_offset, path_length}))
	else $error("stalled result changed");

	// a good url carries no error code and a nonzero port
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> error == 3'd0 && port != 16'd0)
	else $error("valid result with error or zero port");

	// a failed url carries a code and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> error != 3'd0 && port == 16'd0 && !port_given
			&& host_offset == 4'd0 && host_length == 8'd0 && path_offset == 16'd0
			&& path_length == 10'd0 && !is_tls && scheme_code == 2'd0)
	else $error("failed result with nonzero fields");

	// tls flag follows the scheme, the host is not empty and the host offset fits a scheme
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> (is_tls == (scheme_code == 2'd1 || scheme_code == 2'd3))
			&& host_length != 8'd0 && (host_offset == 4'd7 || host_offset == 4'd8
			|| host_offset == 4'd5 || host_offset == 4'd6))
	else $error("scheme fields inconsistent");

endmodule

bind url_stream_parser usp_checker u_usp_checker (.*);

`default_nettype wire
